@@ rtl/sxfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sxfr_pkg
// Shared types and constants for the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package sxfr_pkg;

  localparam logic [7:0] SyncFirst  = 8'hBE;
  localparam logic [7:0] SyncSecond = 8'hEF;

  localparam logic [7:0] SizeZeroRst = 8'd4;
  localparam logic [7:0] SizeOneRst  = 8'd255;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgSizeZero = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeOne  = 2'd1;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhSync2 = 3'd1,
    PhLen   = 3'd2,
    PhId    = 3'd3,
    PhData  = 3'd4,
    PhCheck = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindGood = 2'd1,
    KindBad  = 2'd2,
    KindLen  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] frame_id;
    logic       last;
  } res_t;

endpackage

@@ rtl/sxfr_core.sv @@
// ----------------------------------------------------------------------------
// sxfr_core
// Frame parser: phase machine, length check and running XOR checksum.
// ----------------------------------------------------------------------------
module sxfr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       size_zero_i,
  input  logic [7:0]       size_one_i,
  output logic             res_valid_o,
  output sxfr_pkg::res_t   res_o
);
  import sxfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] id_q, id_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] chk_q, chk_d;
  logic       len_ok;
  logic [8:0] seen_inc;

  // Length check against the size configured for this id
  always_comb begin
    priority if (rx_byte_i == 8'd0) begin
      len_ok = (len_q == size_zero_i);
    end else if (rx_byte_i == 8'd1) begin
      len_ok = (len_q == size_one_i);
    end else begin
      len_ok = 1'b0;
    end
    if (len_q == 8'd0) begin
      len_ok = 1'b0;
    end
  end

  assign seen_inc = {1'b0, seen_q} + 9'd1;

  // Next state and result
  always_comb begin
    phase_d        = phase_q;
    len_d          = len_q;
    id_d           = id_q;
    seen_d         = seen_q;
    chk_d          = chk_q;
    res_valid_o    = 1'b0;
    res_o.kind     = KindData;
    res_o.value    = 8'd0;
    res_o.frame_id = id_q;
    res_o.last     = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PhSync2: begin
          phase_d = (rx_byte_i == SyncSecond) ? PhLen : PhHunt;
        end
        PhLen: begin
          len_d   = rx_byte_i;
          phase_d = PhId;
        end
        PhId: begin
          id_d           = rx_byte_i;
          res_o.frame_id = rx_byte_i;
          if (!len_ok) begin
            phase_d     = PhHunt;
            res_valid_o = 1'b1;
            res_o.kind  = KindLen;
            res_o.last  = 1'b1;
          end else begin
            chk_d   = len_q ^ rx_byte_i;
            seen_d  = 8'd0;
            phase_d = (len_q == 8'd1) ? PhCheck : PhData;
          end
        end
        PhData: begin
          chk_d       = chk_q ^ rx_byte_i;
          seen_d      = seen_inc[7:0];
          res_valid_o = 1'b1;
          res_o.kind  = KindData;
          res_o.value = rx_byte_i;
          if ((seen_inc + 9'd1) >= {1'b0, len_q}) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          phase_d     = PhHunt;
          res_valid_o = 1'b1;
          res_o.kind  = (rx_byte_i == chk_q) ? KindGood : KindBad;
          res_o.last  = 1'b1;
        end
        default: begin
          phase_d = (rx_byte_i == SyncFirst) ? PhSync2 : PhHunt;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= 8'd0;
      id_q    <= 8'd0;
      seen_q  <= 8'd0;
      chk_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      id_q    <= id_d;
      seen_q  <= seen_d;
      chk_q   <= chk_d;
    end
  end

endmodule

@@ rtl/sync_length_xor_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver_top
// Deframer for 0xBE 0xEF, length, id, data, XOR checksum byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per word on rx_byte_i, taken when
//   in_valid_i is high and in_stall_o is low.
//   Output channel: zero or one result word per input word (kind, value,
//   frame_id, last), taken when out_valid_o is high and out_stall_i is low.
//   Data bytes come out as kind 0; a frame ends with one status word
//   (good, checksum bad or length mismatch) that has last set.
//   Config channel: cfg_index_i 0 sets the size for id 0, 1 the size for
//   id 1; other indexes are ignored. Write only while the block is idle.
//   Output timing: a result is registered and appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle when not stalled, set by the single output
//   register; a new byte is taken while that register drains in the same cycle.
//   Stall: while the output word is held by out_stall_i, in_stall_o is
//   high and no byte is taken.
//   Reset: parser hunts for 0xBE, sizes return to 4 and 255, output empty.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    value_o,
  output logic [7:0]                    frame_id_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sxfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import sxfr_pkg::*;

  logic [7:0] size_zero_q;
  logic [7:0] size_one_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       step;
  logic       res_valid;
  res_t       res;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_zero_q <= SizeZeroRst;
      size_one_q  <= SizeOneRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSizeZero) begin
        size_zero_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgSizeOne) begin
        size_one_q <= cfg_data_i;
      end
    end
  end

  // Stall input only while the held result word cannot leave
  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  sxfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (rx_byte_i),
    .size_zero_i (size_zero_q),
    .size_one_i  (size_one_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new result, else drop the delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !in_stall_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign value_o     = out_q.value;
  assign frame_id_o  = out_q.frame_id;
  assign last_o      = out_q.last;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length/XOR frame receiver. A byte-level
// deframer model tracks parser state and sizes, and predicts every result word.
// A scoreboard compares each accepted word, field by field, with the oldest
// prediction. Directed frames hit sync and length corner cases. Random phases
// then reprogram the sizes and stream mostly well-formed frames mixed with noise
// and broken sync. Random gaps on both sides and one long output hold-off
// back-pressure the input.
// ----------------------------------------------------------------------------
module tb;
  import sxfr_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // Deframer model plus queue of expected result words
  class deframe_scoreboard;
    phase_e     ph = PhHunt;
    logic [7:0] flen = 8'd0;
    logic [7:0] cur_id = 8'd0;
    logic [7:0] seen = 8'd0;
    logic [7:0] chk = 8'd0;
    logic [7:0] size_zero = SizeZeroRst;
    logic [7:0] size_one = SizeOneRst;
    res_t       expected_words[$];
    int         errors = 0;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      if (idx == CfgSizeZero) size_zero = data;
      else if (idx == CfgSizeOne) size_one = data;
    endfunction

    function void add_word(kind_e k, logic [7:0] v, logic l);
      res_t w;
      w.kind = k;
      w.value = v;
      w.frame_id = cur_id;
      w.last = l;
      expected_words.push_back(w);
    endfunction

    // Advance the parser by one received byte
    function void predict_byte(logic [7:0] b);
      logic ok;
      case (ph)
        PhSync2: ph = (b == SyncSecond) ? PhLen : PhHunt;
        PhLen: begin
          flen = b;
          ph = PhId;
        end
        PhId: begin
          cur_id = b;
          if (b == 8'd0) ok = (flen == size_zero);
          else if (b == 8'd1) ok = (flen == size_one);
          else ok = 1'b0;
          // a frame always carries its id, so length zero never fits
          if (flen == 8'd0) ok = 1'b0;
          if (!ok) begin
            ph = PhHunt;
            add_word(KindLen, 8'd0, 1'b1);
          end else begin
            chk = flen ^ b;
            seen = 8'd0;
            ph = (flen == 8'd1) ? PhCheck : PhData;
          end
        end
        PhData: begin
          chk = chk ^ b;
          seen = seen + 8'd1;
          if ({1'b0, seen} + 9'd1 >= {1'b0, flen}) ph = PhCheck;
          add_word(KindData, b, 1'b0);
        end
        PhCheck: begin
          ph = PhHunt;
          add_word((b == chk) ? KindGood : KindBad, 8'd0, 1'b1);
        end
        default: ph = (b == SyncFirst) ? PhSync2 : PhHunt;
      endcase
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(res_t got);
      res_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d value %02h id %02h last %0b",
                         got.kind, got.value, got.frame_id, got.last));
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value %02h, want %02h", got.value, want.value));
      if (got.frame_id !== want.frame_id)
        report($sformatf("frame_id %02h, want %02h", got.frame_id, want.frame_id));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          rx_byte = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          kind;
  logic [7:0]          value;
  logic [7:0]          frame_id;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [7:0]          cfg_data = 8'd0;

  deframe_scoreboard   sb;
  bit                  in_burst = 1'b0;
  bit                  out_burst = 1'b0;
  bit                  hold_req = 1'b0;
  int                  frame_bytes = 0;
  int unsigned         cycles = 0;

  sync_length_xor_frame_receiver_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .value_o     (value),
    .frame_id_o  (frame_id),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Give up when the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check delivered words first, then predict from the byte taken at this edge
  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        got.kind = kind_e'(kind);
        got.value = value;
        got.frame_id = frame_id;
        got.last = last;
        sb.check_word(got);
      end
      if (in_valid && in_stall === 1'b0) sb.predict_byte(rx_byte);
    end
  end

  // Result sink: random stall before each word, one long hold-off on request
  initial begin
    int unsigned hold;
    forever begin
      if (hold_req) begin
        hold = HoldCycles;
        hold_req = 1'b0;
      end else begin
        hold = out_burst ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    frame_bytes++;
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  task automatic program_sizes(input logic [7:0] s0, input logic [7:0] s1);
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? CfgIdxSpareLo : CfgIdxSpareHi, 8'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(CfgSizeZero, s0);
      write_reg(CfgSizeOne, s1);
    end else begin
      write_reg(CfgSizeOne, s1);
      write_reg(CfgSizeZero, s0);
    end
    cfg_valid <= 1'b0;
  endtask

  // Push the parser back to hunting, then drain every expected word
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.ph != PhHunt) begin
      send_byte(8'h00);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input bit corrupt);
    logic [7:0] cs;
    logic [7:0] d;
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(len);
    send_byte(id);
    cs = len ^ id;
    for (int i = 1; i < len; i++) begin
      d = 8'($urandom);
      cs = cs ^ d;
      send_byte(d);
    end
    if (corrupt) cs = cs ^ 8'($urandom_range(1, 255));
    send_byte(cs);
  endtask

  task automatic send_random_frame();
    int unsigned sel;
    int unsigned n;
    bit ok0;
    bit ok1;
    logic [7:0] id;
    logic [7:0] len;
    sel = $urandom_range(0, 9);
    ok0 = (sb.size_zero >= 8'd1 && sb.size_zero <= 8'd16);
    ok1 = (sb.size_one >= 8'd1 && sb.size_one <= 8'd16);
    if (ok0 && ok1) id = 8'($urandom_range(0, 1));
    else id = ok0 ? 8'd0 : 8'd1;
    len = (id == 8'd0) ? sb.size_zero : sb.size_one;
    if (sel <= 6) begin
      send_frame(id, len, sel == 6);
    end else if (sel == 7) begin
      // header whose length does not fit the id
      id = $urandom_range(0, 1) ? 8'($urandom_range(0, 2)) : 8'($urandom);
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      if ((id == 8'd0 && len == sb.size_zero) || (id == 8'd1 && len == sb.size_one))
        len = len ^ 8'h80;
      send_byte(SyncFirst);
      send_byte(SyncSecond);
      send_byte(len);
      send_byte(id);
    end else if (sel == 8) begin
      // line noise, kept free of the first sync byte
      n = $urandom_range(1, 4);
      repeat (n) begin
        len = 8'($urandom);
        send_byte((len == SyncFirst) ? 8'h00 : len);
      end
    end else begin
      // first sync byte followed by anything but the second
      len = 8'($urandom);
      send_byte(SyncFirst);
      send_byte((len == SyncSecond) ? 8'h00 : len);
    end
  endtask

  initial begin
    logic [7:0] dir_a [0:26];
    logic [7:0] s0;
    logic [7:0] s1;
    int budget;
    // broken sync; good id 0; good length-one id 1; unknown id; bad checksum;
    // id 1 with the wrong length
    dir_a = '{SyncFirst, SyncFirst, SyncSecond,
              SyncFirst, SyncSecond, 8'h02, 8'h00, 8'hFF, 8'hFD,
              SyncFirst, SyncSecond, 8'h01, 8'h01, 8'h00,
              SyncFirst, SyncSecond, 8'h02, 8'h07,
              SyncFirst, SyncSecond, 8'h01, 8'h01, 8'h55,
              SyncFirst, SyncSecond, 8'h05, 8'h01};
    sb = new;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    program_sizes(8'd2, 8'd1);
    foreach (dir_a[i]) send_byte(dir_a[i]);
    settle();
    // length zero is rejected even with a zero size programmed
    program_sizes(8'd0, 8'd255);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(8'h00);
    send_byte(8'h00);
    settle();

    // Random phases
    budget = 0;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        s0 = 8'd1;
        s1 = 8'd255;
      end else if (p == 1) begin
        s0 = 8'd255;
        s1 = 8'd1;
      end else begin
        s0 = 8'($urandom_range(1, 6));
        s1 = 8'($urandom_range(1, 6));
      end
      program_sizes(s0, s1);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      budget += (p == 0) ? 330 : 75;
      if (p == 0) send_frame(8'd1, 8'd255, 1'b0);
      if (p == 3) begin
        // hold the sink off while bytes keep coming
        in_burst = 1'b1;
        hold_req = 1'b1;
      end
      while (frame_bytes < budget) send_random_frame();
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sxfr_pkg.sv
rtl/sxfr_core.sv
rtl/sync_length_xor_frame_receiver_top.sv
verif/tb.sv
